// ===== hw/rtl/vsm_pkg.sv =====
// Shared widths and request/response types for the vector set-magnitude unit.
package vsm_pkg;

   localparam int CompWidth  = 32;
   localparam int SumWidth   = 2 * CompWidth;
   localparam int RemWidth   = 4 * CompWidth - 1;
   localparam int DeltaWidth = 4 * CompWidth + 2;
   localparam int RootWidth  = CompWidth + 1;

   typedef struct packed {
      logic signed [CompWidth-1:0] vec_x;
      logic signed [CompWidth-1:0] vec_y;
      logic signed [CompWidth-1:0] vec_z;
      logic signed [CompWidth-1:0] target_length;
   } vsm_req_type;

   typedef struct packed {
      logic signed [CompWidth-1:0] out_x;
      logic signed [CompWidth-1:0] out_y;
      logic signed [CompWidth-1:0] out_z;
      logic                        zero_vector;
      logic                        saturated;
   } vsm_rsp_type;

endpackage

// ===== hw/rtl/vector3_set_magnitude_unit.sv =====
// Pipeline: 4 front stages, 33 root stages and one output stage.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Each root stage resolves one result bit per component with one wide
// add and compare. Synchronous reset clears the valid bits only.
module vector3_set_magnitude_unit
   import vsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vsm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output vsm_rsp_type rsp_data
);

   localparam int W  = CompWidth;
   localparam int NS = RootWidth;
   localparam logic [RootWidth-1:0] NegLimit = RootWidth'(1) << (W - 1);
   localparam logic [RootWidth-1:0] PosLimit = NegLimit - RootWidth'(1);

   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } side_type;

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: magnitudes and signs
   side_type       s1_ff, s2_ff, s3_ff, s4_ff;
   logic [W-1:0]   mag_ff [0:2];
   logic [W-1:0]   tmag_ff;
   logic [W-1:0]   mag_in [0:2];
   logic [W-1:0]   tmag_in;
   logic [2:0]     cneg;
   logic           tneg;
   logic [W-1:0]   comp [0:2];

   always_comb begin
      comp[0] = req_data.vec_x;
      comp[1] = req_data.vec_y;
      comp[2] = req_data.vec_z;
      tneg    = req_data.target_length[W-1];
      tmag_in = tneg ? ~req_data.target_length + W'(1) : req_data.target_length;
      for (int i = 0; i < 3; i++) begin
         cneg[i]   = comp[i][W-1];
         mag_in[i] = cneg[i] ? ~comp[i] + W'(1) : comp[i];
      end
   end

   // stage 2: squares and component-target products
   logic [SumWidth-1:0] sq_ff [0:2];
   logic [SumWidth-1:0] p_ff  [0:2];
   // stage 3: sum of squares and partial products of P*P
   logic [SumWidth-1:0] s3_sum_ff;
   logic [SumWidth-1:0] hh_ff [0:2];
   logic [SumWidth-1:0] hl_ff [0:2];
   logic [SumWidth-1:0] ll_ff [0:2];
   // stage 4: 4*P*P per component
   logic [SumWidth-1:0] s4_sum_ff;
   logic [RemWidth-1:0] rem_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= req_valid;
         s2_ff.valid <= s1_ff.valid;
         s3_ff.valid <= s2_ff.valid;
         s4_ff.valid <= s3_ff.valid;
      end
      if (advance) begin
         s1_ff.zero <= (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
         s1_ff.neg  <= cneg ^ {3{tneg}};
         tmag_ff    <= tmag_in;
         s2_ff.zero <= s1_ff.zero;
         s2_ff.neg  <= s1_ff.neg;
         s3_ff.zero <= s2_ff.zero;
         s3_ff.neg  <= s2_ff.neg;
         s4_ff.zero <= s3_ff.zero;
         s4_ff.neg  <= s3_ff.neg;
         s3_sum_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         s4_sum_ff  <= s3_sum_ff;
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            sq_ff[i]  <= SumWidth'(mag_ff[i]) * SumWidth'(mag_ff[i]);
            p_ff[i]   <= SumWidth'(mag_ff[i]) * SumWidth'(tmag_ff);
            hh_ff[i]  <= SumWidth'(p_ff[i][SumWidth-1:W]) * SumWidth'(p_ff[i][SumWidth-1:W]);
            hl_ff[i]  <= SumWidth'(p_ff[i][SumWidth-1:W]) * SumWidth'(p_ff[i][W-1:0]);
            ll_ff[i]  <= SumWidth'(p_ff[i][W-1:0]) * SumWidth'(p_ff[i][W-1:0]);
            rem_ff[i] <= ((RemWidth'(hh_ff[i]) << SumWidth)
                        + (RemWidth'(hl_ff[i]) << (W + 1))
                        + RemWidth'(ll_ff[i])) << 2;
         end
      end
   end

   logic [RootWidth-1:0] root [0:2];

   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_lane
         vsm_root_lane u_lane (
            .clock    (clock),
            .advance  (advance),
            .rem_in   (rem_ff[c]),
            .sum_in   (s4_sum_ff),
            .root_out (root[c])
         );
      end
   endgenerate

   // side band follows the root stages
   side_type side_ff [0:NS];
   assign side_ff[0] = s4_ff;

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_side
         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[k+1].valid <= 1'b0;
            end else if (advance) begin
               side_ff[k+1].valid <= side_ff[k].valid;
            end
            if (advance) begin
               side_ff[k+1].zero <= side_ff[k].zero;
               side_ff[k+1].neg  <= side_ff[k].neg;
            end
         end
      end
   endgenerate

   // output stage: round, sign and clamp, and clear a zero vector
   logic [W-1:0]         res  [0:2];
   logic [2:0]           sat;
   logic [RootWidth:0]   up   [0:2];
   logic [RootWidth-1:0] n    [0:2];
   side_type             last;

   always_comb begin
      last = side_ff[NS];
      for (int i = 0; i < 3; i++) begin
         up[i]  = (RootWidth + 1)'(root[i]) + (RootWidth + 1)'(1);
         n[i]   = up[i][RootWidth:1];
         sat[i] = 1'b0;
         if (last.neg[i]) begin
            if (n[i] > NegLimit) begin
               n[i]   = NegLimit;
               sat[i] = 1'b1;
            end
            res[i] = ~n[i][W-1:0] + W'(1);
         end else begin
            if (n[i] > PosLimit) begin
               n[i]   = PosLimit;
               sat[i] = 1'b1;
            end
            res[i] = n[i][W-1:0];
         end
         if (last.zero) begin
            res[i] = '0;
            sat[i] = 1'b0;
         end
      end
   end

   logic        rsp_valid_ff;
   vsm_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
      if (advance) begin
         rsp_data_ff.out_x       <= res[0];
         rsp_data_ff.out_y       <= res[1];
         rsp_data_ff.out_z       <= res[2];
         rsp_data_ff.zero_vector <= last.zero;
         rsp_data_ff.saturated   <= |sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0
         && !rsp_data.saturated)
      else $error("zero vector response not cleared");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.out_x == W'(PosLimit) || rsp_data.out_y == W'(PosLimit)
         || rsp_data.out_z == W'(PosLimit) || rsp_data.out_x == W'(NegLimit)
         || rsp_data.out_y == W'(NegLimit) || rsp_data.out_z == W'(NegLimit))
      else $error("saturated flag without a clamped component");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(side_ff[NS]))
      else $error("pipeline moved during a stall");

endmodule

// ===== hw/rtl/vsm_root_lane.sv =====
// Pipelined bit-per-stage search for the largest m with m*m*S <= R.
module vsm_root_lane
   import vsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 advance,
   input  logic [RemWidth-1:0]  rem_in,
   input  logic [SumWidth-1:0]  sum_in,
   output logic [RootWidth-1:0] root_out
);

   logic [RemWidth-1:0]  rem_ff  [0:RootWidth];
   logic [RemWidth-1:0]  prod_ff [0:RootWidth];
   logic [SumWidth-1:0]  sum_ff  [0:RootWidth];
   logic [RootWidth-1:0] root_ff [0:RootWidth];

   assign rem_ff[0]  = rem_in;
   assign prod_ff[0] = '0;
   assign sum_ff[0]  = sum_in;
   assign root_ff[0] = '0;

   genvar k;
   generate
      for (k = 0; k < RootWidth; k++) begin : g_stage
         localparam int Bit = CompWidth - k;
         logic [DeltaWidth-1:0] delta;
         logic                  take;
         logic [RemWidth-1:0]   rem_in_s;
         logic [RemWidth-1:0]   prod_in_s;
         logic [RootWidth-1:0]  root_in_s;

         // prod tracks S*m, so the step cost is S*(2*m*2^b + 2^2b)
         always_comb begin
            delta = (DeltaWidth'(prod_ff[k]) << (Bit + 1))
                  + (DeltaWidth'(sum_ff[k]) << (2 * Bit));
            take  = delta <= DeltaWidth'(rem_ff[k]);
            rem_in_s  = take ? rem_ff[k] - delta[RemWidth-1:0] : rem_ff[k];
            prod_in_s = take ? prod_ff[k] + (RemWidth'(sum_ff[k]) << Bit) : prod_ff[k];
            root_in_s = take ? root_ff[k] | (RootWidth'(1) << Bit) : root_ff[k];
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k+1]  <= rem_in_s;
               prod_ff[k+1] <= prod_in_s;
               sum_ff[k+1]  <= sum_ff[k];
               root_ff[k+1] <= root_in_s;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[RootWidth];

endmodule
